// File: src/uwbc_pkg.sv
// Shared types, constants and the whitespace lookup for the UTF-8 blank-string checker.
package uwbc_pkg;

    // Byte patterns used when classifying a byte
    localparam logic [7:0] MASK_TOP2  = 8'hC0;
    localparam logic [7:0] MASK_TOP3  = 8'hE0;
    localparam logic [7:0] MASK_TOP4  = 8'hF0;
    localparam logic [7:0] MASK_TOP5  = 8'hF8;
    localparam logic [7:0] PAT_CONT   = 8'h80;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    localparam int CP_W      = 21;   // code point width
    localparam int PAYLOAD_W = 6;    // data bits carried by one byte

    // Queue between the classifier and the decoder
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // What a byte is, as seen without decoder state
    typedef enum logic [2:0] {
        KIND_ASCII_SPACE,
        KIND_ASCII_OTHER,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_CONT,
        KIND_INVALID
    } byte_kind_t;

    // Classified byte as it travels through the queue
    typedef struct packed {
        byte_kind_t             kind;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   has;
        logic                   last;
    } item_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic           full;
        logic           empty;
        logic [QCW-1:0] count;
    } q_status_t;

    // Decoder status seen by the top level
    typedef struct packed {
        logic pop;
        logic result_load;
    } back_status_t;

    // Unicode whitespace set
    function automatic logic is_space_cp(input logic [CP_W-1:0] cp);
        return (cp >= 21'h00009 && cp <= 21'h0000D) || cp == 21'h00020 ||
               cp == 21'h00085 || cp == 21'h000A0 || cp == 21'h01680 ||
               (cp >= 21'h02000 && cp <= 21'h0200A) ||
               cp == 21'h02028 || cp == 21'h02029 ||
               cp == 21'h0202F || cp == 21'h0205F || cp == 21'h03000;
    endfunction

endpackage

// File: src/uwbc_front.sv
// Input stage: accepts bytes, classifies them and pushes them into the queue.
module uwbc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,   // last_byte
    input  logic                s_tuser,   // [0] has_byte
    output logic                push_valid,
    input  logic                push_ready,
    output uwbc_pkg::item_t     push_item
);

    logic            valid_reg;
    uwbc_pkg::item_t item_reg;
    uwbc_pkg::item_t item_next;

    // Classify the incoming byte
    always_comb begin
        item_next.has  = s_tuser;
        item_next.last = s_tlast;
        item_next.payload = s_tdata[uwbc_pkg::PAYLOAD_W-1:0];
        priority if (s_tdata < uwbc_pkg::ASCII_LIMIT) begin
            if ((s_tdata >= 8'h09 && s_tdata <= 8'h0D) || s_tdata == 8'h20) begin
                item_next.kind = uwbc_pkg::KIND_ASCII_SPACE;
            end else begin
                item_next.kind = uwbc_pkg::KIND_ASCII_OTHER;
            end
        end else if ((s_tdata & uwbc_pkg::MASK_TOP2) == uwbc_pkg::PAT_CONT) begin
            item_next.kind = uwbc_pkg::KIND_CONT;
        end else if ((s_tdata & uwbc_pkg::MASK_TOP3) == uwbc_pkg::PAT_LEAD2) begin
            item_next.kind    = uwbc_pkg::KIND_LEAD2;
            item_next.payload = {1'b0, s_tdata[4:0]};
        end else if ((s_tdata & uwbc_pkg::MASK_TOP4) == uwbc_pkg::PAT_LEAD3) begin
            item_next.kind    = uwbc_pkg::KIND_LEAD3;
            item_next.payload = {2'b0, s_tdata[3:0]};
        end else if ((s_tdata & uwbc_pkg::MASK_TOP5) == uwbc_pkg::PAT_LEAD4) begin
            item_next.kind    = uwbc_pkg::KIND_LEAD4;
            item_next.payload = {3'b0, s_tdata[2:0]};
        end else begin
            item_next.kind = uwbc_pkg::KIND_INVALID;
        end
    end

    // Stage register: takes a new transaction whenever it empties this cycle
    assign s_tready = !valid_reg || push_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

// File: src/uwbc_queue.sv
// Small FIFO of classified bytes between the classifier and the decoder.
module uwbc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  uwbc_pkg::item_t       push_item,
    output logic                  pop_valid,
    input  logic                  pop,
    output uwbc_pkg::item_t       pop_item,
    output uwbc_pkg::q_status_t   status
);

    uwbc_pkg::item_t                  entry_reg [uwbc_pkg::QDEPTH];
    logic [uwbc_pkg::QAW-1:0]         wr_ptr_reg;
    logic [uwbc_pkg::QAW-1:0]         rd_ptr_reg;
    logic [uwbc_pkg::QCW-1:0]         count_reg;
    logic                             do_push;
    logic                             do_pop;
    logic                             full;
    logic                             empty;

    assign full       = count_reg == uwbc_pkg::QCW'(uwbc_pkg::QDEPTH);
    assign empty      = count_reg == '0;
    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && !empty;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                if (wr_ptr_reg == uwbc_pkg::QAW'(uwbc_pkg::QDEPTH - 1)) begin
                    wr_ptr_reg <= '0;
                end else begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (do_pop) begin
                if (rd_ptr_reg == uwbc_pkg::QAW'(uwbc_pkg::QDEPTH - 1)) begin
                    rd_ptr_reg <= '0;
                end else begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign status.full  = full;
    assign status.empty = empty;
    assign status.count = count_reg;

endmodule

// File: src/uwbc_back.sv
// Decoder: assembles code points, tracks failure and holds the result register.
module uwbc_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     pop_valid,
    output logic                     pop,
    input  uwbc_pkg::item_t          pop_item,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // [0] is_blank, [7:1] zero
    output uwbc_pkg::back_status_t   status
);

    logic [1:0]                  pending_reg;
    logic [1:0]                  pending_next;
    logic [uwbc_pkg::CP_W-1:0]   acc_reg;
    logic [uwbc_pkg::CP_W-1:0]   acc_next;
    logic [uwbc_pkg::CP_W-1:0]   cont_cp;
    logic                        failed_reg;
    logic                        failed_next;
    logic                        m_valid_reg;
    logic                        blank_reg;
    logic                        result_load;

    // An item without a result can always go; a string end waits for a free output
    assign pop = pop_valid && (!pop_item.last || !m_valid_reg || m_tready);
    assign result_load = pop && pop_item.last;

    assign cont_cp = {acc_reg[uwbc_pkg::CP_W-uwbc_pkg::PAYLOAD_W-1:0], pop_item.payload};

    // Sequence decode for one byte
    always_comb begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        failed_next  = failed_reg;
        if (pop_item.has && !failed_reg) begin
            if (pending_reg != 2'd0) begin
                if (pop_item.kind != uwbc_pkg::KIND_CONT) begin
                    failed_next = 1'b1;
                end else begin
                    acc_next     = cont_cp;
                    pending_next = pending_reg - 2'd1;
                    if (pending_reg == 2'd1 && !uwbc_pkg::is_space_cp(cont_cp)) begin
                        failed_next = 1'b1;
                    end
                end
            end else begin
                unique case (pop_item.kind)
                    uwbc_pkg::KIND_ASCII_SPACE: ;
                    uwbc_pkg::KIND_LEAD2: begin
                        acc_next     = uwbc_pkg::CP_W'(pop_item.payload);
                        pending_next = 2'd1;
                    end
                    uwbc_pkg::KIND_LEAD3: begin
                        acc_next     = uwbc_pkg::CP_W'(pop_item.payload);
                        pending_next = 2'd2;
                    end
                    uwbc_pkg::KIND_LEAD4: begin
                        acc_next     = uwbc_pkg::CP_W'(pop_item.payload);
                        pending_next = 2'd3;
                    end
                    uwbc_pkg::KIND_ASCII_OTHER,
                    uwbc_pkg::KIND_CONT,
                    uwbc_pkg::KIND_INVALID: failed_next = 1'b1;
                    default: failed_next = 1'b1;
                endcase
            end
        end
    end

    // Decoder state; cleared at each string end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            acc_reg     <= '0;
            failed_reg  <= 1'b0;
        end else if (pop) begin
            if (pop_item.last) begin
                pending_reg <= 2'd0;
                acc_reg     <= '0;
                failed_reg  <= 1'b0;
            end else begin
                pending_reg <= pending_next;
                acc_reg     <= acc_next;
                failed_reg  <= failed_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (result_load) begin
            blank_reg <= !failed_next && pending_next == 2'd0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, blank_reg};

    assign status.pop         = pop;
    assign status.result_load = result_load;

endmodule

// File: src/utf8_whitespace_blank_check.sv
// Top level of the UTF-8 blank-string checker.
// Takes one UTF-8 byte per cycle on the s_ channel while s_tready is high (tuser[0] marks
// a real byte, tlast ends the string) and, for each string, returns one transaction on
// the m_ channel whose tdata[0] is 1 when the string was empty or made only of well-formed
// Unicode whitespace. Overlong encodings are accepted; the first malformed or non-space
// code point makes the answer 0. Throughput is one byte per cycle unless the queue fills
// or a string end waits for a free output. The closing byte passes the input register,
// the four-entry queue and then the output register before m_tvalid rises. The input
// keeps accepting while a result waits, until the queue fills.
module utf8_whitespace_blank_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // [0] has_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] is_blank, [7:1] zero
);

    logic                     push_valid;
    logic                     push_ready;
    uwbc_pkg::item_t          push_item;
    logic                     pop_valid;
    logic                     pop;
    uwbc_pkg::item_t          pop_item;
    uwbc_pkg::q_status_t      q_status;
    uwbc_pkg::back_status_t   back_status;

    uwbc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    uwbc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item),
        .status     (q_status)
    );

    uwbc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .status    (back_status)
    );

`ifndef NO_ASSERTIONS
    // Fill count stays within the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= uwbc_pkg::QCW'(uwbc_pkg::QDEPTH))
        else $error("queue count beyond depth");

    // Decoder never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // A new result never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.result_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten");

    // A full queue holds off the input stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.full && push_valid) |-> !s_tready)
        else $error("input taken while queue full");
`endif

endmodule
